// ===== sv/pias_pkg.sv =====
// Shared types and constants for the point-in-aperture test core.
// No dependencies; every other file but pias_if imports this package.
`default_nettype none

package pias_pkg;

  localparam int unsigned PIPE_DEPTH = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_MODE = 3'd0,
    CFG_FAST_LIMIT = 3'd1,
    CFG_RECT_HW    = 3'd2,
    CFG_RECT_HH    = 3'd3,
    CFG_ELL_HW_SQ  = 3'd4,
    CFG_ELL_RATIO  = 3'd5,
    CFG_OCT_TAN    = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] SHAPE_CIRCLE   = 3'd0;
  localparam logic [2:0] SHAPE_RECT     = 3'd1;
  localparam logic [2:0] SHAPE_ELLIPSE  = 3'd2;
  localparam logic [2:0] SHAPE_RECT_ELL = 3'd3;
  localparam logic [2:0] SHAPE_OCTAGON  = 3'd4;

  typedef struct packed {
    logic [2:0]  shape_mode;
    logic [30:0] fast_limit;
    logic [30:0] rect_hw;
    logic [30:0] rect_hh;
    logic [62:0] ell_hw_sq;
    logic [31:0] ell_ratio;
    logic [31:0] oct_tan;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    shape_mode: 3'd0,
    fast_limit: 31'd0,
    rect_hw:    31'd0,
    rect_hh:    31'd0,
    ell_hw_sq:  63'd0,
    ell_ratio:  32'h0001_0000,
    oct_tan:    32'h0001_0000
  };

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic fast_in;
    logic rect_out;
    logic circ_out;
    logic ell_out;
  } shape_flags_t;

endpackage

`default_nettype wire

// ===== sv/pias_if.sv =====
// Stream interfaces for the point and result channels.
// Standalone; used by the top level of the point-in-aperture core.
`default_nettype none

interface pias_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface pias_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

// ===== sv/point_in_aperture_shape_test_core.sv =====
// Point-in-aperture test core: top level, magnitude and result stages.
// An accepted point passes the eight registered stages, magnitude to result, before out_ch.
// Throughput: one point per cycle unless out_ch holds back; each of the eight stages holds only when full.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on pias_pkg, pias_if, pias_cfg_regs, pias_pipe_ctrl and the two test units.
`default_nettype none

module point_in_aperture_shape_test_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pias_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pias_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  pias_in_if.sink                          in_ch,
  pias_out_if.source                       out_ch
);
  import pias_pkg::*;

  cfg_t         cfg;
  pipe_ctrl_t   pc;
  shape_flags_t flags6;
  logic         corner_out6;
  logic [31:0]  ux, uy, ax0_r, ay0_r;
  logic         shape_in, inside_r;

  pias_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pias_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .pc        (pc)
  );

  assign ux = in_ch.pos_x;
  assign uy = in_ch.pos_y;

  always_ff @(posedge clk) begin
    if (pc.en[0]) begin
      ax0_r <= ux[31] ? (~ux + 32'd1) : ux;
      ay0_r <= uy[31] ? (~uy + 32'd1) : uy;
    end
  end

  pias_shape_unit u_shape (
    .clk    (clk),
    .pc     (pc),
    .cfg    (cfg),
    .ax0    (ax0_r),
    .ay0    (ay0_r),
    .flags6 (flags6)
  );

  pias_corner_unit u_corner (
    .clk         (clk),
    .pc          (pc),
    .cfg         (cfg),
    .ax0         (ax0_r),
    .ay0         (ay0_r),
    .corner_out6 (corner_out6)
  );

  always_comb begin
    case (cfg.shape_mode)
      SHAPE_CIRCLE:   shape_in = !flags6.circ_out;
      SHAPE_RECT:     shape_in = !flags6.rect_out;
      SHAPE_ELLIPSE:  shape_in = !flags6.ell_out;
      SHAPE_RECT_ELL: shape_in = !flags6.ell_out && !flags6.rect_out;
      SHAPE_OCTAGON:  shape_in = !flags6.rect_out && !corner_out6;
      default:        shape_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pc.en[PIPE_DEPTH-1]) begin
      inside_r <= flags6.fast_in || shape_in;
    end
  end

  assign in_ch.ready       = pc.en[0];
  assign out_ch.valid      = pc.vld[PIPE_DEPTH-1];
  assign out_ch.inside_res = inside_r;

endmodule

`default_nettype wire

// ===== sv/pias_cfg_regs.sv =====
// Configuration register file for the aperture shape and its bounds.
// Depends on pias_pkg.
`default_nettype none

module pias_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pias_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pias_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pias_pkg::cfg_t                   cfg
);
  import pias_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SHAPE_MODE: cfg_nxt.shape_mode = cfg_wdata[2:0];
        CFG_FAST_LIMIT: cfg_nxt.fast_limit = cfg_wdata[30:0];
        CFG_RECT_HW:    cfg_nxt.rect_hw    = cfg_wdata[30:0];
        CFG_RECT_HH:    cfg_nxt.rect_hh    = cfg_wdata[30:0];
        CFG_ELL_HW_SQ:  cfg_nxt.ell_hw_sq  = cfg_wdata[62:0];
        CFG_ELL_RATIO:  cfg_nxt.ell_ratio  = cfg_wdata[31:0];
        CFG_OCT_TAN:    cfg_nxt.oct_tan    = cfg_wdata[31:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/pias_pipe_ctrl.sv =====
// Valid and load-enable chain for the eight-stage pipeline.
// Depends on pias_pkg.
`default_nettype none

module pias_pipe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output pias_pkg::pipe_ctrl_t  pc
);
  import pias_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt, en;

  always_comb begin
    en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pc.en  = en;
  assign pc.vld = vld_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((~en) & (~vld_r)) == '0)
    else $error("stage stalled while empty");

  a_free_output_opens_input: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld_r[PIPE_DEPTH-1] || out_ready) |-> en[0])
    else $error("input blocked while output side is free");

  a_output_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (en[PIPE_DEPTH-1] && vld_r[PIPE_DEPTH-2]) |=> vld_r[PIPE_DEPTH-1])
    else $error("transaction lost entering output stage");

endmodule

`default_nettype wire

// ===== sv/pias_shape_unit.sv =====
// Fast-accept, rectangle, circle and ellipse tests, stages 1 to 6.
// Depends on pias_pkg; fed by the magnitude stage of the top level.
`default_nettype none

module pias_shape_unit (
  input  logic                    clk,
  input  pias_pkg::pipe_ctrl_t    pc,
  input  pias_pkg::cfg_t          cfg,
  input  logic [31:0]             ax0,
  input  logic [31:0]             ay0,
  output pias_pkg::shape_flags_t  flags6
);
  import pias_pkg::*;

  shape_flags_t f1_r, f2_r, f3_r, f4_r, f5_r, f6_r;
  logic [63:0]  x2_1_r, y2_1_r, x2_2_r, yr_lo_2_r, yr_hi_2_r;
  logic [63:0]  circ_sum;
  logic [95:0]  lhs_3_r;

  assign circ_sum = x2_1_r + y2_1_r;

  always_ff @(posedge clk) begin
    if (pc.en[1]) begin
      f1_r.fast_in  <= ({1'b0, ax0} + {1'b0, ay0}) < {2'b00, cfg.fast_limit};
      f1_r.rect_out <= (ax0 >= {1'b0, cfg.rect_hw}) || (ay0 >= {1'b0, cfg.rect_hh});
      f1_r.circ_out <= 1'b0;
      f1_r.ell_out  <= 1'b0;
      x2_1_r        <= 64'(ax0) * 64'(ax0);
      y2_1_r        <= 64'(ay0) * 64'(ay0);
    end
    if (pc.en[2]) begin
      f2_r.fast_in  <= f1_r.fast_in;
      f2_r.rect_out <= f1_r.rect_out;
      f2_r.circ_out <= circ_sum >= {1'b0, cfg.ell_hw_sq};
      f2_r.ell_out  <= f1_r.ell_out;
      x2_2_r        <= x2_1_r;
      yr_lo_2_r     <= 64'(y2_1_r[31:0]) * 64'(cfg.ell_ratio);
      yr_hi_2_r     <= 64'(y2_1_r[63:32]) * 64'(cfg.ell_ratio);
    end
    if (pc.en[3]) begin
      f3_r    <= f2_r;
      lhs_3_r <= {16'd0, x2_2_r, 16'd0} + {32'd0, yr_lo_2_r} + {yr_hi_2_r, 32'd0};
    end
    if (pc.en[4]) begin
      f4_r.fast_in  <= f3_r.fast_in;
      f4_r.rect_out <= f3_r.rect_out;
      f4_r.circ_out <= f3_r.circ_out;
      f4_r.ell_out  <= lhs_3_r >= {17'd0, cfg.ell_hw_sq, 16'd0};
    end
    if (pc.en[5]) begin
      f5_r <= f4_r;
    end
    if (pc.en[6]) begin
      f6_r <= f5_r;
    end
  end

  assign flags6 = f6_r;

endmodule

`default_nettype wire

// ===== sv/pias_corner_unit.sv =====
// Octagon corner-cut test, stages 1 to 6, with split 63x63 products.
// Depends on pias_pkg; fed by the magnitude stage of the top level.
`default_nettype none

module pias_corner_unit (
  input  logic                  clk,
  input  pias_pkg::pipe_ctrl_t  pc,
  input  pias_pkg::cfg_t        cfg,
  input  logic [31:0]           ax0,
  input  logic [31:0]           ay0,
  output logic                  corner_out6
);
  import pias_pkg::*;

  function automatic logic [62:0] mag63(input logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    return m[62:0];
  endfunction

  logic [62:0]  c2_1_r, c1p_1_r;
  logic [31:0]  ax_1_r, ay_1_r;
  logic [63:0]  c1_2_r, c3_2_r, dy_2_r, dx_2_r;
  logic [62:0]  m_a1_3_r, m_b1_3_r, m_a2_3_r, m_b2_3_r;
  logic         n1_3_r, n2_3_r, n1_4_r, n2_4_r, n1_5_r, n2_5_r;
  logic [63:0]  p1_ll_r, p2_ll_r;
  logic [62:0]  p1_lh_r, p1_hl_r, p2_lh_r, p2_hl_r;
  logic [61:0]  p1_hh_r, p2_hh_r;
  logic [125:0] m1_5_r, m2_5_r;
  logic         neg1, neg2, le_res, corner_out_r;

  always_comb begin
    neg1   = n1_5_r && (m1_5_r != '0);
    neg2   = n2_5_r && (m2_5_r != '0);
    le_res = (neg1 && !neg2) ||
             (!neg1 && !neg2 && (m1_5_r <= m2_5_r)) ||
             (neg1 && neg2 && (m1_5_r >= m2_5_r));
  end

  always_ff @(posedge clk) begin
    if (pc.en[1]) begin
      c2_1_r  <= 63'(cfg.rect_hw) * 63'(cfg.oct_tan);
      c1p_1_r <= 63'(cfg.rect_hh) * 63'(cfg.oct_tan);
      ax_1_r  <= ax0;
      ay_1_r  <= ay0;
    end
    if (pc.en[2]) begin
      c1_2_r <= {1'b0, c1p_1_r} - {17'd0, cfg.rect_hw, 16'd0};
      c3_2_r <= {17'd0, cfg.rect_hh, 16'd0} - {1'b0, c2_1_r};
      dy_2_r <= {16'd0, ay_1_r, 16'd0} - {1'b0, c2_1_r};
      dx_2_r <= {16'd0, ax_1_r, 16'd0} - {17'd0, cfg.rect_hw, 16'd0};
    end
    if (pc.en[3]) begin
      m_a1_3_r <= mag63(c1_2_r);
      m_b1_3_r <= mag63(dy_2_r);
      m_a2_3_r <= mag63(c3_2_r);
      m_b2_3_r <= mag63(dx_2_r);
      n1_3_r   <= c1_2_r[63] ^ dy_2_r[63];
      n2_3_r   <= c3_2_r[63] ^ dx_2_r[63];
    end
    if (pc.en[4]) begin
      p1_ll_r <= 64'(m_a1_3_r[31:0]) * 64'(m_b1_3_r[31:0]);
      p1_lh_r <= 63'(m_a1_3_r[31:0]) * 63'(m_b1_3_r[62:32]);
      p1_hl_r <= 63'(m_a1_3_r[62:32]) * 63'(m_b1_3_r[31:0]);
      p1_hh_r <= 62'(m_a1_3_r[62:32]) * 62'(m_b1_3_r[62:32]);
      p2_ll_r <= 64'(m_a2_3_r[31:0]) * 64'(m_b2_3_r[31:0]);
      p2_lh_r <= 63'(m_a2_3_r[31:0]) * 63'(m_b2_3_r[62:32]);
      p2_hl_r <= 63'(m_a2_3_r[62:32]) * 63'(m_b2_3_r[31:0]);
      p2_hh_r <= 62'(m_a2_3_r[62:32]) * 62'(m_b2_3_r[62:32]);
      n1_4_r  <= n1_3_r;
      n2_4_r  <= n2_3_r;
    end
    if (pc.en[5]) begin
      m1_5_r <= 126'(p1_ll_r) + (126'(p1_lh_r) << 32) + (126'(p1_hl_r) << 32) +
                (126'(p1_hh_r) << 64);
      m2_5_r <= 126'(p2_ll_r) + (126'(p2_lh_r) << 32) + (126'(p2_hl_r) << 32) +
                (126'(p2_hh_r) << 64);
      n1_5_r <= n1_4_r;
      n2_5_r <= n2_4_r;
    end
    if (pc.en[6]) begin
      corner_out_r <= le_res;
    end
  end

  assign corner_out6 = corner_out_r;

endmodule

`default_nettype wire
